### rtl/core/jca_pkg.sv
package jca_pkg;

  // Default parameter values
  localparam int TICK_MS_DEF   = 10;
  localparam int FRAC_BITS_DEF = 16;

  // Q30 bases of the two exponentials
  localparam longint unsigned Q30_ONE        = 64'd1073741824;
  localparam longint unsigned Q30_HALF       = 64'd536870912;
  localparam longint unsigned BASE_HUNDREDTH = 64'd1063059017;
  localparam longint unsigned BASE_TENTH     = 64'd971571854;

  // Button timing limits in ms and the scale maximum
  localparam logic [9:0] HOLD_LIMIT_MS    = 10'd500;
  localparam logic [9:0] HOLD_MAX         = 10'd1023;
  localparam logic [7:0] REPEAT_LIMIT_MS  = 8'd100;
  localparam logic [8:0] RELEASE_LIMIT_MS = 9'd250;
  localparam logic [7:0] SCALE_MAX        = 8'd255;

  // Register indexes
  localparam logic [1:0] REG_ADJUST_ENABLE    = 2'd0;
  localparam logic [1:0] REG_TANK_MODE        = 2'd1;
  localparam logic [1:0] REG_LEFT_SCALE_INIT  = 2'd2;
  localparam logic [1:0] REG_RIGHT_SCALE_INIT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL1,
    ST_MID,
    ST_MUL2,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [7:0] left_axis;
    logic signed [7:0] right_axis;
    logic              left_up_btn;
    logic              left_down_btn;
    logic              right_up_btn;
    logic              right_down_btn;
  } in_t;

  typedef struct packed {
    logic signed [7:0] left_shaped;
    logic signed [7:0] right_shaped;
    logic [7:0]        left_scale_now;
    logic [7:0]        right_scale_now;
    logic              save_left;
    logic              save_right;
  } out_t;

  // Power of a Q30 base, rounded to frac fraction bits (elaboration only)
  function automatic longint unsigned exp_frac(longint unsigned base, int n, int frac);
    longint unsigned p;
    p = Q30_ONE;
    for (int k = 0; k < n; k++) begin
      p = (p * base + Q30_HALF) >> 30;
    end
    return (p + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

  // Step a scale up with saturation or down with clamping
  function automatic logic [7:0] step_scale(logic [7:0] s, logic up);
    logic [7:0] r;
    r = s;
    if (up) begin
      if (s != SCALE_MAX) r = s + 8'd1;
    end else begin
      if (s != 8'd0) r = s - 8'd1;
    end
    return r;
  endfunction

endpackage

### rtl/core/joystick_curve_autorepeat_adjust.sv
// Joystick exponential curve with button-adjusted curve scales.
// Input channel in_valid/in_ready/in_data carries one control tick: two stick
// axes and four button levels. Output channel out_valid/out_ready/out_data
// carries the shaped axes, the current scales and the save pulses.
// Each tick first updates the button timers and scales, then shapes both
// axes with one shared bit-serial multiplier that retires one multiplier bit
// per cycle: two products of FRAC_BITS+1 steps per axis. A new tick is
// accepted only once the previous one has been shaped on both axes and
// handed to the output register.
// The result sits in an output register, so the next tick is accepted while
// a finished result waits; if the receiver stalls past the next computation,
// that computation holds in its final state until the register frees up.
// Reset clears the state machine, the button state, the scales and the
// registers (adjust_enable comes up 1). Registers are written over the APB
// port at byte address 4*index; writing a scale init also loads that scale.
module joystick_curve_autorepeat_adjust #(
  parameter int TICK_MS   = jca_pkg::TICK_MS_DEF,
  parameter int FRAC_BITS = jca_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jca_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jca_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int W  = FRAC_BITS + 1;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);
  localparam logic [W-1:0]  ONE      = W'(1) << FRAC_BITS;

  jca_pkg::state_t state, state_next;

  // Configuration and running scales
  logic       adjust_enable, tank_mode;
  logic [7:0] left_scale_init, right_scale_init;
  logic [7:0] left_scale, right_scale;

  // Button state
  logic       locked [4];
  logic       pend   [4];
  logic [9:0] hold   [4];
  logic [7:0] rep    [4];
  logic [8:0] rel    [4];

  logic       locked_next [4];
  logic       pend_next   [4];
  logic [9:0] hold_next   [4];
  logic [7:0] rep_next    [4];
  logic [8:0] rel_next    [4];
  logic [7:0] lsc_next, rsc_next;
  logic       save_l_next, save_r_next;

  // Datapath
  logic signed [7:0] ax0, ax1, sh0, sh1;
  logic              save_l, save_r;
  logic              axis_sel;
  logic [W-1:0]      a_val, mcand;
  logic [2*W:0]      prod;
  logic [CW-1:0]     cnt;
  logic [7:0]        mag_in;
  logic              neg, bypass;
  logic signed [7:0] x_cur;

  // Curve tables
  logic [W-1:0] a_tab [256];
  logic [W-1:0] b_tab [128];

  for (genvar g = 0; g < 256; g++) begin : g_a_tab
    assign a_tab[g] = W'(jca_pkg::exp_frac(jca_pkg::BASE_HUNDREDTH, g, FRAC_BITS));
  end
  for (genvar g = 0; g < 128; g++) begin : g_b_tab
    assign b_tab[g] = W'(jca_pkg::exp_frac(jca_pkg::BASE_TENTH, g, FRAC_BITS));
  end

  logic       cfg_wr;
  logic [3:0] btn;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign btn = {in_data.right_down_btn, in_data.right_up_btn,
                in_data.left_down_btn, in_data.left_up_btn};

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      jca_pkg::REG_ADJUST_ENABLE:    prdata = {31'd0, adjust_enable};
      jca_pkg::REG_TANK_MODE:        prdata = {31'd0, tank_mode};
      jca_pkg::REG_LEFT_SCALE_INIT:  prdata = {24'd0, left_scale_init};
      jca_pkg::REG_RIGHT_SCALE_INIT: prdata = {24'd0, right_scale_init};
      default:                       prdata = 32'd0;
    endcase
  end

  // Button timers and scale steps, in button order
  always_comb begin
    logic        en, act, sv;
    logic [10:0] hsum;
    logic [9:0]  hnew;
    logic [7:0]  rsum;
    logic [8:0]  lsum;
    lsc_next = left_scale;
    rsc_next = right_scale;
    save_l_next = 1'b0;
    save_r_next = 1'b0;
    for (int i = 0; i < 4; i++) begin
      locked_next[i] = locked[i];
      pend_next[i]   = pend[i];
      hold_next[i]   = hold[i];
      rep_next[i]    = rep[i];
      rel_next[i]    = rel[i];
      act  = 1'b0;
      sv   = 1'b0;
      hsum = 11'd0;
      hnew = 10'd0;
      rsum = 8'd0;
      lsum = 9'd0;
      en = adjust_enable & ((i < 2) | ~tank_mode);
      if (en) begin
        if (btn[i] && !locked[i]) begin
          act = 1'b1;
          locked_next[i] = 1'b1;
          pend_next[i] = 1'b1;
        end else if (btn[i]) begin
          hsum = {1'b0, hold[i]} + 11'(TICK_MS);
          hnew = (hsum > {1'b0, jca_pkg::HOLD_MAX}) ? jca_pkg::HOLD_MAX : hsum[9:0];
          hold_next[i] = hnew;
          if (hnew > jca_pkg::HOLD_LIMIT_MS) begin
            rsum = rep[i] + 8'(TICK_MS);
            if (rsum > jca_pkg::REPEAT_LIMIT_MS) begin
              act = 1'b1;
              rep_next[i] = 8'd0;
            end else begin
              rep_next[i] = rsum;
            end
          end
        end else begin
          locked_next[i] = 1'b0;
          hold_next[i] = 10'd0;
          if (pend[i]) begin
            lsum = rel[i] + 9'(TICK_MS);
            if (lsum > jca_pkg::RELEASE_LIMIT_MS) begin
              sv = 1'b1;
              rel_next[i] = 9'd0;
              pend_next[i] = 1'b0;
            end else begin
              rel_next[i] = lsum;
            end
          end
        end
      end
      if (act) begin
        if (i < 2) lsc_next = jca_pkg::step_scale(lsc_next, (i % 2) == 0);
        else       rsc_next = jca_pkg::step_scale(rsc_next, (i % 2) == 0);
      end
      if (sv) begin
        if (i < 2) save_l_next = 1'b1;
        else       save_r_next = 1'b1;
      end
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    unique case (state)
      jca_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = jca_pkg::ST_LOAD;
      end
      jca_pkg::ST_LOAD:  state_next = jca_pkg::ST_MUL1;
      jca_pkg::ST_MUL1:  if (cnt == CNT_LAST) state_next = jca_pkg::ST_MID;
      jca_pkg::ST_MID:   state_next = jca_pkg::ST_MUL2;
      jca_pkg::ST_MUL2:  if (cnt == CNT_LAST) state_next = jca_pkg::ST_STORE;
      jca_pkg::ST_STORE: state_next = axis_sel ? jca_pkg::ST_DONE : jca_pkg::ST_LOAD;
      jca_pkg::ST_DONE:  if (!out_valid || out_ready) state_next = jca_pkg::ST_IDLE;
      default:           state_next = jca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= jca_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Control state: registers, scales, buttons, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_enable <= 1'b1;
      tank_mode <= 1'b0;
      left_scale_init <= 8'd0;
      right_scale_init <= 8'd0;
      left_scale <= 8'd0;
      right_scale <= 8'd0;
      out_valid <= 1'b0;
      axis_sel <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        locked[i] <= 1'b0;
        pend[i] <= 1'b0;
        hold[i] <= 10'd0;
        rep[i] <= 8'd0;
        rel[i] <= 9'd0;
      end
    end else begin
      // advance buttons on an accepted transaction
      if (state == jca_pkg::ST_IDLE && in_valid) begin
        left_scale <= lsc_next;
        right_scale <= rsc_next;
        axis_sel <= 1'b0;
        for (int i = 0; i < 4; i++) begin
          locked[i] <= locked_next[i];
          pend[i] <= pend_next[i];
          hold[i] <= hold_next[i];
          rep[i] <= rep_next[i];
          rel[i] <= rel_next[i];
        end
      end
      if (state == jca_pkg::ST_STORE) axis_sel <= 1'b1;
      // register writes
      if (cfg_wr) begin
        unique case (paddr[3:2])
          jca_pkg::REG_ADJUST_ENABLE: adjust_enable <= pwdata[0];
          jca_pkg::REG_TANK_MODE:     tank_mode <= pwdata[0];
          jca_pkg::REG_LEFT_SCALE_INIT: begin
            left_scale_init <= pwdata[7:0];
            left_scale <= pwdata[7:0];
          end
          jca_pkg::REG_RIGHT_SCALE_INIT: begin
            right_scale_init <= pwdata[7:0];
            right_scale <= pwdata[7:0];
          end
          default: ;
        endcase
      end
      // output register valid
      if (state == jca_pkg::ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Shaping datapath with the serial multiplier
  always_ff @(posedge clk) begin
    logic [7:0]   s;
    logic [7:0]   m;
    logic [6:0]   idx;
    logic [W:0]   sum;
    logic [W-1:0] f;
    logic [7:0]   mag;
    s   = axis_sel ? (tank_mode ? left_scale : right_scale) : left_scale;
    m   = x_cur[7] ? 8'(-x_cur) : 8'(x_cur);
    idx = 7'd127 - ((m > 8'd127) ? 7'd127 : m[6:0]);
    sum = prod[2*W-1:W] + (prod[0] ? {1'b0, mcand} : '0);
    f   = a_val + prod[FRAC_BITS +: W];
    mag = prod[FRAC_BITS +: 8];
    unique case (state)
      jca_pkg::ST_IDLE: begin
        // hold the axes of the accepted transaction
        if (in_valid) begin
          ax0 <= in_data.left_axis;
          ax1 <= in_data.right_axis;
          save_l <= save_l_next;
          save_r <= save_r_next;
        end
      end
      jca_pkg::ST_LOAD: begin
        a_val  <= a_tab[s];
        mcand  <= ONE - a_tab[s];
        prod   <= {{(W+1){1'b0}}, b_tab[idx]};
        cnt    <= '0;
        mag_in <= m;
        neg    <= x_cur[7];
        bypass <= (s == 8'd0);
      end
      jca_pkg::ST_MUL1, jca_pkg::ST_MUL2: begin
        prod <= {1'b0, sum, prod[W-1:1]};
        cnt  <= cnt + CW'(1);
      end
      jca_pkg::ST_MID: begin
        mcand <= f;
        prod  <= {{(W+1){1'b0}}, W'(mag_in)};
        cnt   <= '0;
      end
      jca_pkg::ST_STORE: begin
        if (axis_sel) sh1 <= bypass ? x_cur : (neg ? 8'(-mag) : mag);
        else          sh0 <= bypass ? x_cur : (neg ? 8'(-mag) : mag);
      end
      jca_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.left_shaped <= sh0;
          out_data.right_shaped <= sh1;
          out_data.left_scale_now <= left_scale;
          out_data.right_scale_now <= right_scale;
          out_data.save_left <= save_l;
          out_data.save_right <= save_r;
        end
      end
      default: ;
    endcase
  end

  assign x_cur = axis_sel ? ax1 : ax0;

endmodule

### bench/tb_joystick_curve_autorepeat_adjust.sv
`timescale 1ns / 100ps

module tb_joystick_curve_autorepeat_adjust;

  localparam int TICK = 10;
  localparam int FRAC = 16;
  localparam int LATENCY = 4 * (FRAC + 1) + 7;
  localparam longint CYCLE_LIMIT = 2000000;

  // Output predictor with its own copy of scales and button timers
  class curve_scoreboard;
    jca_pkg::out_t pending[$];
    int errors;
    bit en_r;
    bit tank_r;
    logic [7:0] lscale;
    logic [7:0] rscale;
    bit locked[4];
    bit save_pend[4];
    int unsigned hold[4];
    int unsigned rep[4];
    int unsigned rel[4];

    function void clear();
      en_r = 1; tank_r = 0; lscale = 0; rscale = 0;
      for (int i = 0; i < 4; i++) begin
        locked[i] = 0; save_pend[i] = 0; hold[i] = 0; rep[i] = 0; rel[i] = 0;
      end
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      case (idx)
        jca_pkg::REG_ADJUST_ENABLE: en_r = v[0];
        jca_pkg::REG_TANK_MODE: tank_r = v[0];
        jca_pkg::REG_LEFT_SCALE_INIT: lscale = v[7:0];
        jca_pkg::REG_RIGHT_SCALE_INIT: rscale = v[7:0];
        default: ;
      endcase
    endfunction

    function longint unsigned power_frac(longint unsigned base, int n);
      longint unsigned p;
      p = jca_pkg::Q30_ONE;
      for (int k = 0; k < n; k++) p = (p * base + jca_pkg::Q30_HALF) >> 30;
      return (p + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    endfunction

    function logic [7:0] curve(logic signed [7:0] x, logic [7:0] s);
      int m, mb;
      longint unsigned a, b, f, mag;
      if (s == 0) return x;
      m = (x < 0) ? -int'(x) : int'(x);
      mb = (m > 127) ? 127 : m;
      a = power_frac(jca_pkg::BASE_HUNDREDTH, s);
      b = power_frac(jca_pkg::BASE_TENTH, 127 - mb);
      f = a + ((b * ((64'd1 << FRAC) - a)) >> FRAC);
      mag = (f * m) >> FRAC;
      return (x < 0) ? 8'(-mag) : 8'(mag);
    endfunction

    function void bump(int i);
      if (i < 2) begin
        if (i % 2 == 0) begin if (lscale != 255) lscale++; end
        else if (lscale != 0) lscale--;
      end else begin
        if (i % 2 == 0) begin if (rscale != 255) rscale++; end
        else if (rscale != 0) rscale--;
      end
    endfunction

    function bit button(int i, bit pressed);
      bit pulse;
      pulse = 0;
      if (pressed && !locked[i]) begin
        bump(i); locked[i] = 1; save_pend[i] = 1;
      end else if (pressed) begin
        hold[i] = (hold[i] + TICK > 1023) ? 1023 : hold[i] + TICK;
        if (hold[i] > 500) begin
          rep[i] = (rep[i] + TICK) & 8'hFF;
          if (rep[i] > 100) begin bump(i); rep[i] = 0; end
        end
      end else begin
        locked[i] = 0; hold[i] = 0;
        if (save_pend[i]) begin
          rel[i] = (rel[i] + TICK) & 9'h1FF;
          if (rel[i] > 250) begin pulse = 1; rel[i] = 0; save_pend[i] = 0; end
        end
      end
      return pulse;
    endfunction

    function void note_tick(jca_pkg::in_t t);
      jca_pkg::out_t r;
      bit sl, sr;
      sl = 0; sr = 0;
      if (en_r) begin
        sl |= button(0, t.left_up_btn);
        sl |= button(1, t.left_down_btn);
        if (!tank_r) begin
          sr |= button(2, t.right_up_btn);
          sr |= button(3, t.right_down_btn);
        end
      end
      r.left_shaped = curve(t.left_axis, lscale);
      r.right_shaped = curve(t.right_axis, tank_r ? lscale : rscale);
      r.left_scale_now = lscale;
      r.right_scale_now = rscale;
      r.save_left = sl;
      r.save_right = sr;
      pending.push_back(r);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  jca_pkg::in_t in_data = '0;
  jca_pkg::out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  curve_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  longint cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  joystick_curve_autorepeat_adjust DUT (.*);

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    sb.errors++;
  endtask

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (sb.pending.size() == 0) report("unexpected result", 1, 0);
      else begin
        jca_pkg::out_t w;
        w = sb.pending.pop_front();
        if (out_data.left_shaped !== w.left_shaped)
          report("left_shaped", out_data.left_shaped, w.left_shaped);
        if (out_data.right_shaped !== w.right_shaped)
          report("right_shaped", out_data.right_shaped, w.right_shaped);
        if (out_data.left_scale_now !== w.left_scale_now)
          report("left_scale_now", out_data.left_scale_now, w.left_scale_now);
        if (out_data.right_scale_now !== w.right_scale_now)
          report("right_scale_now", out_data.right_scale_now, w.right_scale_now);
        if (out_data.save_left !== w.save_left)
          report("save_left", out_data.save_left, w.save_left);
        if (out_data.save_right !== w.save_right)
          report("save_right", out_data.save_right, w.save_right);
      end
    end
  end

  // Drive the receiver ready at the falling edge
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(int idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(idx * 4); pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_tick(jca_pkg::in_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid <= 1; in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic jca_pkg::in_t rand_tick();
    jca_pkg::in_t t;
    t.left_axis = 8'($urandom);
    t.right_axis = 8'($urandom);
    {t.left_up_btn, t.left_down_btn, t.right_up_btn, t.right_down_btn} = 4'($urandom);
    return t;
  endfunction

  // Hold a button pattern for a stretch of ticks so repeat and save timers run
  task automatic press_run(logic [3:0] btns, int n);
    jca_pkg::in_t t;
    for (int k = 0; k < n; k++) begin
      t = rand_tick();
      {t.left_up_btn, t.left_down_btn, t.right_up_btn, t.right_down_btn} = btns;
      send_tick(t);
    end
  endtask

  initial begin
    jca_pkg::in_t t;
    int phase;
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: axis extremes at zero and nonzero scales, then button presses and releases
    write_reg(jca_pkg::REG_LEFT_SCALE_INIT, 0);
    t = '0; t.left_axis = -128; t.right_axis = 127; send_tick(t);
    t.left_axis = 0; t.right_axis = -127; send_tick(t);
    drain();
    write_reg(jca_pkg::REG_LEFT_SCALE_INIT, 255);
    write_reg(jca_pkg::REG_RIGHT_SCALE_INIT, 1);
    t = '0; t.left_axis = -128; t.right_axis = 127; send_tick(t);
    t.left_axis = 127; t.right_axis = -127; send_tick(t);
    t.left_axis = 1; t.right_axis = -1; send_tick(t);
    t.left_up_btn = 1; t.right_down_btn = 1; send_tick(t);
    t = '0; t.left_up_btn = 1; t.left_down_btn = 1; t.right_up_btn = 1;
    t.right_down_btn = 1; send_tick(t);
    press_run(4'b0000, 30);
    drain();
    write_reg(jca_pkg::REG_RIGHT_SCALE_INIT, 0);
    press_run(4'b0001, 3);
    drain();

    // Random phases over several register settings and idling mixes
    for (phase = 0; phase < 8; phase++) begin
      write_reg(jca_pkg::REG_ADJUST_ENABLE, (phase % 4) != 3);
      write_reg(jca_pkg::REG_TANK_MODE, (phase % 3) == 1);
      write_reg(jca_pkg::REG_LEFT_SCALE_INIT, (phase == 2) ? 255 : $urandom_range(255));
      write_reg(jca_pkg::REG_RIGHT_SCALE_INIT, (phase == 5) ? 0 : $urandom_range(255));
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 60; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 60; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      if (phase == 4) begin
        hold_off = 1;
        fork
          begin repeat (600) @(posedge clk); hold_off = 0; end
          press_run(4'b1000, 20);
        join
      end
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(3) == 0) begin
          for (int j = 0; j < 5; j++) send_tick(rand_tick());
        end else begin
          press_run(4'($urandom), $urandom_range(1, 80));
          press_run(4'b0000, $urandom_range(1, 30));
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

### filelist.f
rtl/core/jca_pkg.sv
rtl/core/joystick_curve_autorepeat_adjust.sv
bench/tb_joystick_curve_autorepeat_adjust.sv
